// ===== rtl/dvd_pkg.sv =====
// ----------------------------------------------------------------------------
// dvd_pkg: shared types and constants for the dent displacement unit
// Command codes, controller command struct and fixed-point limits.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int DENT_SLOTS_DEF = 16;
  localparam logic [15:0] DEPTH_MIN = 16'd13;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch request and start
    logic wr;        // store dent
    logic rd;        // read slot at index
    logic pipe_go;   // launch dent into arithmetic
    logic clr;       // clear accumulators
    logic fin;       // saturate and present result
  } dvd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;      // arithmetic still holds a dent
  } dvd_sts_t;

endpackage

// ===== rtl/dvd_datapath.sv =====
// ----------------------------------------------------------------------------
// dvd_datapath: dent table and per-dent arithmetic
// Holds the dent stores and runs one dent at a time through distance, root,
// divide and falloff steps, summing the terms per axis.
// ----------------------------------------------------------------------------
module dvd_datapath import dvd_pkg::*; #(
  parameter int DENT_SLOTS = DENT_SLOTS_DEF,
  parameter int IW = (DENT_SLOTS > 1) ? $clog2(DENT_SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  dvd_cmd_t           cmd_c,
  output dvd_sts_t           sts,
  input  logic [IW-1:0]      rd_idx,
  input  logic [3:0]         slot,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] nrm_x,
  input  logic signed [15:0] nrm_y,
  input  logic signed [15:0] nrm_z,
  input  logic [15:0]        radius,
  input  logic [15:0]        depth,
  output logic signed [23:0] off_x,
  output logic signed [23:0] off_y,
  output logic signed [23:0] off_z
);

  localparam int ACW = 32;

  // dent stores
  logic [23:0] cx_mem [DENT_SLOTS];
  logic [23:0] cy_mem [DENT_SLOTS];
  logic [23:0] cz_mem [DENT_SLOTS];
  logic [47:0] n_mem  [DENT_SLOTS];
  logic [15:0] r_mem  [DENT_SLOTS];
  logic [15:0] dep    [DENT_SLOTS];

  logic signed [23:0] vx, vy, vz;
  logic [23:0] rcx, rcy, rcz;
  logic [47:0] rn;
  logic [15:0] rr, rdep;
  logic [IW-1:0] wr_idx;

  assign wr_idx = IW'(slot);

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd_c.wr && {28'd0, slot} < DENT_SLOTS) begin
      cx_mem[wr_idx] <= pos_x;
      cy_mem[wr_idx] <= pos_y;
      cz_mem[wr_idx] <= pos_z;
      n_mem[wr_idx]  <= {nrm_z, nrm_y, nrm_x};
      r_mem[wr_idx]  <= radius;
    end
    if (cmd_c.rd) begin
      rcx <= cx_mem[rd_idx];
      rcy <= cy_mem[rd_idx];
      rcz <= cz_mem[rd_idx];
      rn  <= n_mem[rd_idx];
      rr  <= r_mem[rd_idx];
    end
    if (cmd_c.load) begin
      vx <= pos_x;
      vy <= pos_y;
      vz <= pos_z;
    end
  end

  // depth store clears at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DENT_SLOTS; i++) dep[i] <= '0;
    end else if (cmd_c.wr && {28'd0, slot} < DENT_SLOTS) begin
      dep[wr_idx] <= depth;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_c.rd) rdep <= dep[rd_idx];
  end

  // sequencer of arithmetic steps for one dent
  localparam logic [2:0] P_IDLE = 3'd0, P_DIF = 3'd1, P_SQ = 3'd2, P_SUM = 3'd3,
                         P_SQRT = 3'd4, P_DIV = 3'd5, P_FALL = 3'd6, P_TERM = 3'd7;
  logic [2:0] ps;
  logic [5:0] cnt;
  logic signed [24:0] dx, dy, dz;
  logic [49:0] qx, qy, qz;
  logic in_range;
  logic [67:0] rem_s;
  logic [33:0] root;
  logic [67:0] sq_x;
  logic [31:0] num;
  logic [16:0] t16;
  logic [25:0] drem;
  logic [16:0] f;
  logic [1:0] tax;
  logic [32:0] df;
  logic signed [ACW-1:0] sx, sy, sz;

  logic [69:0] trial;
  logic [26:0] dtrial;
  logic signed [15:0] ncomp;
  logic signed [49:0] prod;
  logic [49:0] mag;
  logic [20:0] rnd;
  logic signed [ACW-1:0] term;

  assign trial = {rem_s[65:0], sq_x[67:66]} - {34'd0, root, 2'b01};
  assign dtrial = {drem[25:0], num[31]} - {11'd0, rr};
  assign in_range = (52'(qx) + 52'(qy) + 52'(qz)) < 52'(rr * rr);

  always_comb begin
    case (tax)
      2'd0:    ncomp = rn[15:0];
      2'd1:    ncomp = rn[31:16];
      default: ncomp = rn[47:32];
    endcase
    prod = -($signed({1'b0, df}) * ncomp);
    mag = prod[49] ? 50'(-prod) : prod;
    rnd = 21'((mag + 50'd536870912) >> 30);
    term = prod[49] ? -ACW'(rnd) : ACW'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= P_IDLE;
    end else begin
      case (ps)
        P_IDLE: if (cmd_c.pipe_go) ps <= P_DIF;
        P_DIF:  ps <= P_SQ;
        P_SQ:   ps <= P_SUM;
        P_SUM:  ps <= (rdep >= DEPTH_MIN && in_range) ? P_SQRT : P_IDLE;
        P_SQRT: if (cnt == 6'd33) ps <= P_DIV;
        P_DIV:  if (cnt == 6'd31) ps <= P_FALL;
        P_FALL: ps <= P_TERM;
        P_TERM: if (tax == 2'd2) ps <= P_IDLE;
        default: ps <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ps)
      P_DIF: begin
        dx <= 25'(vx) - 25'($signed(rcx));
        dy <= 25'(vy) - 25'($signed(rcy));
        dz <= 25'(vz) - 25'($signed(rcz));
      end
      P_SQ: begin
        qx <= 50'(dx * dx);
        qy <= 50'(dy * dy);
        qz <= 50'(dz * dz);
      end
      P_SUM: begin
        rem_s <= '0;
        root <= '0;
        cnt <= '0;
      end
      default: ;
    endcase
    if (ps == P_SUM) sq_x <= {(52'(qx) + 52'(qy) + 52'(qz)), 16'd0};
    // restoring square root, one result bit per cycle
    if (ps == P_SQRT) begin
      sq_x <= {sq_x[65:0], 2'b00};
      if (!trial[69]) begin
        rem_s <= trial[67:0];
        root <= {root[32:0], 1'b1};
      end else begin
        rem_s <= {rem_s[65:0], sq_x[67:66]};
        root <= {root[32:0], 1'b0};
      end
      cnt <= (cnt == 6'd33) ? 6'd0 : cnt + 6'd1;
      drem <= '0;
    end
    // load numerator after the root settles
    if (ps == P_SQRT && cnt == 6'd33) begin
      num <= {6'd0, {2'b0, rr, 8'd0} -
              26'(trial[69] ? {root[32:0], 1'b0} : {root[32:0], 1'b1})} << 8;
    end
    // restoring divide, one quotient bit per cycle
    if (ps == P_DIV) begin
      num <= {num[30:0], ~dtrial[26]};
      drem <= dtrial[26] ? {drem[24:0], num[31]} : dtrial[25:0];
      cnt <= (cnt == 6'd31) ? 6'd0 : cnt + 6'd1;
      if (cnt == 6'd31) t16 <= {num[15:0], ~dtrial[26]};
    end
    // first term step only waits for depth times falloff
    if (ps == P_FALL) begin
      f <= 17'((34'(t16) * 34'(t16)) >> 16);
      tax <= 2'd3;
    end
    if (ps == P_TERM) tax <= tax + 2'd1;
  end

  // depth times falloff, ready from the second term step
  always_ff @(posedge clk) begin
    df <= 33'(rdep) * 33'(f);
  end

  // accumulate terms
  always_ff @(posedge clk) begin
    if (cmd_c.clr) begin
      sx <= '0; sy <= '0; sz <= '0;
    end else if (ps == P_TERM && tax != 2'd3) begin
      case (tax)
        2'd0:    sx <= sx + term;
        2'd1:    sy <= sy + term;
        default: sz <= sz + term;
      endcase
    end
  end

  function automatic logic signed [23:0] sat(input logic signed [ACW-1:0] v);
    if (v > 32'sd8388607) return 24'sd8388607;
    if (v < -32'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd_c.fin) begin
      off_x <= sat(sx);
      off_y <= sat(sy);
      off_z <= sat(sz);
    end
  end

  assign sts.busy = (ps != P_IDLE) || cmd_c.pipe_go;

endmodule

// ===== rtl/dvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvd_ctrl: request sequencer for the dent displacement unit
// Accepts requests, walks the slots on evaluate, hands out the result.
// ----------------------------------------------------------------------------
module dvd_ctrl import dvd_pkg::*; #(
  parameter int DENT_SLOTS = DENT_SLOTS_DEF,
  parameter int IW = (DENT_SLOTS > 1) ? $clog2(DENT_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output dvd_cmd_t      cmd_c,
  input  dvd_sts_t      sts,
  output logic [IW-1:0] rd_idx
);

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_GO = 3'd2, S_WAIT = 3'd3,
                         S_FIN = 3'd4, S_OUT = 3'd5;
  logic [2:0] state;
  logic [IW:0] idx;
  logic acc;

  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign rd_idx = idx[IW-1:0];

  always_comb begin
    cmd_c = '0;
    cmd_c.load = acc;
    cmd_c.wr = acc && cmd == CMD_WRITE;
    cmd_c.clr = acc;
    cmd_c.rd = (state == S_RD);
    cmd_c.pipe_go = (state == S_GO);
    cmd_c.fin = (state == S_FIN);
  end

  // walk slots: read, launch, wait for arithmetic; then finish and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: if (acc && cmd == CMD_EVAL) begin
          state <= S_RD;
          idx <= '0;
        end
        S_RD:   state <= S_GO;
        S_GO:   state <= S_WAIT;
        S_WAIT: if (!sts.busy) begin
          if (idx == (IW+1)'(DENT_SLOTS - 1)) state <= S_FIN;
          else begin
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> in_stall) else $error("request taken while busy");

endmodule

// ===== rtl/dent_vertex_displacement_unit.sv =====
// ----------------------------------------------------------------------------
// dent_vertex_displacement_unit: dent table with vertex displacement
// Write requests store the dent without leaving the idle state. Evaluate requests
// walk every slot: a slot that fails the depth or range test ends after the sum
// step; a contributing slot runs a 34-step square root, a 32-step divide, the
// falloff step and four term steps; the result is then saturated and presented.
// One request at a time. Synchronous reset clears the depth table and control.
// ----------------------------------------------------------------------------
module dent_vertex_displacement_unit import dvd_pkg::*; #(
  parameter int DENT_SLOTS = DENT_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [3:0]         slot,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] nrm_x,
  input  logic signed [15:0] nrm_y,
  input  logic signed [15:0] nrm_z,
  input  logic [15:0]        radius,
  input  logic [15:0]        depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] off_x,
  output logic signed [23:0] off_y,
  output logic signed [23:0] off_z
);

  localparam int IW = (DENT_SLOTS > 1) ? $clog2(DENT_SLOTS) : 1;

  dvd_cmd_t cmd_c;
  dvd_sts_t sts;
  logic [IW-1:0] rd_idx;

  dvd_ctrl #(.DENT_SLOTS(DENT_SLOTS), .IW(IW)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .cmd, .out_valid, .out_stall,
    .cmd_c, .sts, .rd_idx
  );

  dvd_datapath #(.DENT_SLOTS(DENT_SLOTS), .IW(IW)) u_dp (
    .clk, .rst, .cmd_c, .sts, .rd_idx, .slot, .pos_x, .pos_y, .pos_z,
    .nrm_x, .nrm_y, .nrm_z, .radius, .depth, .off_x, .off_y, .off_z
  );

endmodule
